>>> design/cgpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpq_pkg
// Shared types and constants of the credit gated packet queue.
// ----------------------------------------------------------------------------
package cgpq_pkg;

  localparam int QUEUE_DEPTH_DEF      = 8;
  localparam int MAX_PACKET_BYTES_DEF = 32;

  localparam int CH_W   = 16;
  localparam int BYTE_W = 8;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_BYTE   = 2'd0;
  localparam cmd_t CMD_CREDIT = 2'd1;
  localparam cmd_t CMD_OPEN   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DIRECT = 2'd0;
  localparam status_t ST_QUEUED = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_SEND,
    S_DECIDE
  } state_t;

endpackage

>>> design/credit_gated_packet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_gated_packet_queue
// Outgoing packet ring with cut-through send, credit retry and full reject.
// ----------------------------------------------------------------------------
// Non-final byte, credit miss, open and unused codes: no results, never busy.
// Sending a packet: a slot read in S_HEAD for a queued one, then one byte read
// from the byte memory per cycle; each result shows in the cycle after its read.
// Last byte: head sent first if link ready; S_DECIDE then sends, queues or rejects it.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous active-low reset clears indices, staged count and sequencer.
module credit_gated_packet_queue #(
  parameter int QUEUE_DEPTH      = cgpq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PACKET_BYTES = cgpq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  cgpq_pkg::cmd_t             in_cmd,
  input  logic [cgpq_pkg::CH_W-1:0]  in_channel_id,
  input  logic [cgpq_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_last_byte,
  input  logic                       in_link_ready,
  output logic                       out_valid,
  output logic                       out_kind,
  output logic [cgpq_pkg::CH_W-1:0]  out_channel_id,
  output logic [cgpq_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_packet_end,
  output cgpq_pkg::status_t          out_send_status,
  output logic                       out_run_end
);

  import cgpq_pkg::*;

  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES);
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int BDEPTH = QUEUE_DEPTH << IDX_W;
  localparam logic [QW-1:0]    LAST_SLOT = QW'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PACKET_BYTES);

  function automatic logic [QW-1:0] inc_slot(input logic [QW-1:0] x);
    return (x == LAST_SLOT) ? '0 : x + 1'b1;
  endfunction

  logic [BYTE_W-1:0]     byte_mem [BDEPTH];
  logic [CH_W+CNT_W-1:0] slot_mem [QUEUE_DEPTH];

  state_t            state_r, state_nxt;
  logic [QW-1:0]     ins_r, rem_r;
  logic [CNT_W-1:0]  staged_r;
  logic [CNT_W-1:0]  len_r;
  logic [CH_W-1:0]   ch_r;
  logic              ready_r;
  logic              pkt_pend_r;
  logic [QW-1:0]     send_slot_r;
  logic [CNT_W-1:0]  send_len_r;
  logic [IDX_W-1:0]  send_idx_r;
  logic [CH_W-1:0]   send_ch_r;
  logic              send_final_r;
  logic [CH_W+CNT_W-1:0] slot_rd_r;
  logic [BYTE_W-1:0] byte_rd_r;

  logic              out_valid_r, out_kind_r, out_pend_r, out_run_end_r;
  logic [CH_W-1:0]   out_ch_r;
  status_t           out_status_r;

  logic accept, empty, full, direct, room;
  logic byte_we, slot_we;
  logic emit_byte, emit_status, pend;
  status_t status_code;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign empty  = (ins_r == rem_r);
  assign full   = (inc_slot(ins_r) == rem_r);
  assign direct = !full && empty && ready_r;
  assign room   = (staged_r < MAX_CNT);
  assign pend   = (CNT_W'(send_idx_r) == send_len_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_CREDIT && !empty && in_link_ready) begin
          state_nxt = S_HEAD;
        end else if (accept && in_cmd == CMD_BYTE && in_last_byte) begin
          state_nxt = (!empty && in_link_ready) ? S_HEAD : S_DECIDE;
        end
      end
      S_HEAD:   state_nxt = S_SEND;
      S_SEND: begin
        if (pend) begin
          state_nxt = pkt_pend_r ? S_DECIDE : S_IDLE;
        end
      end
      S_DECIDE: state_nxt = direct ? S_SEND : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    byte_we     = accept && (in_cmd == CMD_BYTE) && room;
    slot_we     = (state_r == S_DECIDE) && !full && !direct;
    emit_byte   = (state_r == S_SEND);
    emit_status = (state_r == S_DECIDE) && !direct;
    status_code = full ? ST_FULL : ST_QUEUED;
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[{ins_r, staged_r[IDX_W-1:0]}] <= in_data_byte;
    end
    byte_rd_r <= byte_mem[{send_slot_r, send_idx_r}];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[ins_r] <= {ch_r, len_r};
    end
    slot_rd_r <= slot_mem[rem_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ins_r       <= '0;
      rem_r       <= '0;
      staged_r    <= '0;
      pkt_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_byte || emit_status;
      case (state_r)
        S_IDLE: begin
          if (accept && in_cmd == CMD_OPEN) begin
            ins_r    <= '0;
            rem_r    <= '0;
            staged_r <= '0;
          end else if (accept && in_cmd == CMD_BYTE) begin
            if (in_last_byte) begin
              staged_r   <= '0;
              pkt_pend_r <= 1'b1;
            end else if (room) begin
              staged_r <= staged_r + 1'b1;
            end
          end else if (accept && in_cmd == CMD_CREDIT) begin
            pkt_pend_r <= 1'b0;
          end
        end
        S_HEAD:   rem_r <= inc_slot(rem_r);
        S_DECIDE: begin
          pkt_pend_r <= 1'b0;
          if (slot_we) begin
            ins_r <= inc_slot(ins_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_BYTE && in_last_byte) begin
      len_r   <= room ? staged_r + 1'b1 : staged_r;
      ch_r    <= in_channel_id;
      ready_r <= in_link_ready;
    end
    case (state_r)
      S_IDLE: begin
        send_final_r <= !(in_cmd == CMD_BYTE);
      end
      S_HEAD: begin
        send_slot_r <= rem_r;
        send_ch_r   <= slot_rd_r[CH_W+CNT_W-1:CNT_W];
        send_len_r  <= slot_rd_r[CNT_W-1:0];
        send_idx_r  <= '0;
      end
      S_SEND: begin
        send_idx_r <= send_idx_r + 1'b1;
      end
      S_DECIDE: begin
        send_slot_r  <= ins_r;
        send_ch_r    <= ch_r;
        send_len_r   <= len_r;
        send_idx_r   <= '0;
        send_final_r <= 1'b1;
      end
      default: ;
    endcase
    out_kind_r    <= emit_status;
    out_ch_r      <= emit_byte ? send_ch_r : '0;
    out_pend_r    <= emit_byte && pend;
    out_status_r  <= emit_status ? status_code : ST_DIRECT;
    out_run_end_r <= emit_status || (emit_byte && pend && send_final_r);
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_channel_id  = out_ch_r;
  assign out_byte        = out_kind_r ? '0 : byte_rd_r;
  assign out_packet_end  = out_pend_r;
  assign out_send_status = out_status_r;
  assign out_run_end     = out_run_end_r;

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_run_end && (out_send_status != ST_DIRECT))
    else $error("status result must end its run");

  a_mid_byte_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind && !out_packet_end |-> !out_run_end)
    else $error("run_end on a non-final byte");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without sequencer activity");

  a_head_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HEAD |=> state_r == S_SEND)
    else $error("head read not followed by send");

  a_queue_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |=> ins_r != rem_r)
    else $error("queue write left ring empty");

endmodule

>>> sim/credit_gated_packet_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_gated_packet_queue_tb
// Self-checking bench for the packet queue: directed cases for direct send,
// queueing, credit retry, full reject, overlong cut-through, channel open and
// the unused command, then random packet traffic under three sender gap
// profiles. A scoreboard model predicts every strobed result.
// ----------------------------------------------------------------------------
module credit_gated_packet_queue_tb;
  import cgpq_pkg::*;

  localparam int   QD          = QUEUE_DEPTH_DEF;
  localparam int   MPB         = MAX_PACKET_BYTES_DEF;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   TAIL_CYCLES = 100;
  localparam int   MAX_PRINTS  = 50;
  localparam cmd_t CMD_UNUSED  = 2'd3;
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic          kind;
    logic [15:0]   ch;
    logic [7:0]    data;
    logic          pend;
    status_t       status;
    logic          run_end;
  } tx_result_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  cmd_t               in_cmd          = CMD_BYTE;
  logic [CH_W-1:0]    in_channel_id   = '0;
  logic [BYTE_W-1:0]  in_data_byte    = '0;
  logic               in_last_byte    = 1'b0;
  logic               in_link_ready   = 1'b0;
  logic               busy;
  logic               out_valid;
  logic               out_kind;
  logic [CH_W-1:0]    out_channel_id;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_packet_end;
  status_t            out_send_status;
  logic               out_run_end;

  // scoreboard model state
  logic [7:0]  pkt_mem [QD*MPB];
  logic [15:0] slot_ch [QD];
  int          slot_len [QD];
  int          wr_idx   = 0;
  int          rd_idx   = 0;
  int          fill_cnt = 0;

  tx_result_t  tx_expected [$];
  tx_result_t  head_exp;
  int          err_cnt    = 0;
  int          cycle_cnt  = 0;
  int          idle_pct   = 0;
  int          ready_pct  = 50;

  credit_gated_packet_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_channel_id   (in_channel_id),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_link_ready   (in_link_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_channel_id  (out_channel_id),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .out_send_status (out_send_status),
    .out_run_end     (out_run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("credit_gated_packet_queue_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // ---------------- prediction ----------------
  task automatic emit(input logic kind, input logic [15:0] ch, input logic [7:0] b,
                      input logic pend, input status_t st);
    tx_result_t r;
    r.kind    = kind;
    r.ch      = ch;
    r.data    = b;
    r.pend    = pend;
    r.status  = st;
    r.run_end = 1'b0;
    tx_expected.push_back(r);
  endtask

  task automatic emit_packet(input int slot, input logic [15:0] ch, input int len);
    for (int i = 0; i < len; i++) begin
      emit(KIND_BYTE, ch, pkt_mem[slot*MPB + i], (i == len - 1), ST_DIRECT);
    end
  endtask

  task automatic send_head(input logic ready);
    if (wr_idx != rd_idx && ready) begin
      emit_packet(rd_idx, slot_ch[rd_idx], slot_len[rd_idx]);
      rd_idx = (rd_idx + 1) % QD;
    end
  endtask

  task automatic predict_queue_item(input cmd_t c, input logic [15:0] ch,
                                    input logic [7:0] d, input logic last,
                                    input logic ready);
    int         n0;
    int         len;
    tx_result_t r;
    n0 = tx_expected.size();
    case (c)
      CMD_OPEN: begin
        wr_idx   = 0;
        rd_idx   = 0;
        fill_cnt = 0;
      end
      CMD_CREDIT: begin
        send_head(ready);
      end
      CMD_BYTE: begin
        if (fill_cnt < MPB) begin
          pkt_mem[wr_idx*MPB + fill_cnt] = d;
          fill_cnt++;
        end
        if (last) begin
          len      = fill_cnt;
          fill_cnt = 0;
          send_head(ready);
          if ((QD + rd_idx - wr_idx) % QD == 1) begin
            emit(KIND_STATUS, '0, '0, 1'b0, ST_FULL);
          end else if (wr_idx == rd_idx && ready) begin
            emit_packet(wr_idx, ch, len);
          end else begin
            slot_ch[wr_idx]  = ch;
            slot_len[wr_idx] = len;
            wr_idx           = (wr_idx + 1) % QD;
            emit(KIND_STATUS, '0, '0, 1'b0, ST_QUEUED);
          end
        end
      end
      default: ;
    endcase
    if (tx_expected.size() > n0) begin
      r         = tx_expected.pop_back();
      r.run_end = 1'b1;
      tx_expected.push_back(r);
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (tx_expected.size() == 0) begin
        report_mismatch("result strobed with nothing expected");
      end else begin
        head_exp = tx_expected.pop_front();
        check_field("kind", 16'(out_kind), 16'(head_exp.kind));
        check_field("channel", out_channel_id, head_exp.ch);
        check_field("byte", 16'(out_byte), 16'(head_exp.data));
        check_field("packet_end", 16'(out_packet_end), 16'(head_exp.pend));
        check_field("send_status", 16'(out_send_status), 16'(head_exp.status));
        check_field("run_end", 16'(out_run_end), 16'(head_exp.run_end));
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(input cmd_t c, input logic [15:0] ch, input logic [7:0] d,
                           input logic last, input logic ready);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= c;
    in_channel_id <= ch;
    in_data_byte  <= d;
    in_last_byte  <= last;
    in_link_ready <= ready;
    do @(posedge clk); while (busy);
    predict_queue_item(c, ch, d, last, ready);
  endtask

  // data_pat < 0 gives random bytes; noise_pct mixes credits and unused codes in
  task automatic send_packet(input logic [15:0] ch, input int len, input logic ready,
                             input int data_pat, input int noise_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (data_pat < 0) ? 8'($urandom_range(255)) : 8'(data_pat);
      if (i < len - 1 && $urandom_range(99) < noise_pct) begin
        if ($urandom_range(1)) begin
          send_item(CMD_CREDIT, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          send_item(CMD_UNUSED, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
      if (i == len - 1) begin
        send_item(CMD_BYTE, ch, b, 1'b1, ready);
      end else begin
        send_item(CMD_BYTE, ch, b, 1'b0, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_direct_send;
    send_packet(16'h0000, 1, 1'b1, 8'h00, 0);
    send_packet(16'hFFFF, 3, 1'b1, 8'hFF, 0);
  endtask

  task automatic test_queue_and_credit;
    send_packet(16'h1234, 1, 1'b0, -1, 0);
    send_packet(16'h8001, 2, 1'b0, -1, 0);
    send_item(CMD_CREDIT, 16'h0, 8'h0, 1'b0, 1'b0);
    send_item(CMD_CREDIT, 16'h0, 8'h0, 1'b0, 1'b1);
    send_item(CMD_CREDIT, 16'h0, 8'h0, 1'b1, 1'b1);
    send_item(CMD_CREDIT, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_full_reject;
    for (int i = 0; i < QD; i++) begin
      send_packet(16'(16'h0100 + i), 1, 1'b0, -1, 0);
    end
    send_packet(16'h5A5A, 2, 1'b1, -1, 0);
    send_item(CMD_OPEN, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_overlong_cut_through;
    send_packet(16'hA5A5, MPB, 1'b0, -1, 0);
    send_packet(16'h3C3C, MPB + 1, 1'b1, -1, 0);
  endtask

  task automatic test_open_discard;
    send_item(CMD_BYTE, 16'h1111, 8'h11, 1'b0, 1'b1);
    send_item(CMD_BYTE, 16'h2222, 8'h22, 1'b0, 1'b0);
    send_item(CMD_OPEN, 16'h0, 8'h0, 1'b0, 1'b0);
    send_packet(16'h7777, 1, 1'b1, 8'h77, 0);
  endtask

  task automatic test_unused_code;
    send_item(CMD_BYTE, 16'h4444, 8'h44, 1'b0, 1'b0);
    send_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_BYTE, 16'h4545, 8'h45, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int n_items);
    int         sent;
    int         sel;
    int         len;
    logic [15:0] ch;
    sent     = 0;
    idle_pct = gap_pct;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        send_item(CMD_OPEN, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (sel < 5) begin
        send_item(CMD_UNUSED, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (sel < 20) begin
        send_item(CMD_CREDIT, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(99) < ready_pct));
        sent++;
      end else begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(2))
            0:       ready_pct = 15;
            1:       ready_pct = 50;
            default: ready_pct = 85;
          endcase
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(1, MPB + 8) : $urandom_range(1, 6);
        case ($urandom_range(7))
          0:       ch = 16'h0000;
          1:       ch = 16'hFFFF;
          default: ch = 16'($urandom_range(16'hFFFF));
        endcase
        send_packet(ch, len, 1'($urandom_range(99) < ready_pct), -1, 5);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 36;
    test_direct_send();
    test_queue_and_credit();
    test_full_reject();
    test_overlong_cut_through();
    test_open_discard();
    test_unused_code();

    test_random_traffic(36, 110);
    test_random_traffic(62, 110);
    test_random_traffic(0, 110);

    @(negedge clk);
    start <= 1'b0;
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tx_expected.size() != 0) begin
      report_mismatch("expected results never arrived");
    end
    if (err_cnt == 0) begin
      $display("credit_gated_packet_queue_tb OK");
    end else begin
      $display("credit_gated_packet_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
